FILE: sv/framed_decimal_packet_parser_top_assert.svh
// Assertion macros for the framed decimal packet parser.
// Used by the RTL files that carry concurrent checks; no other dependencies.
`ifndef FRAMED_DECIMAL_PACKET_PARSER_TOP_ASSERT_SVH
`define FRAMED_DECIMAL_PACKET_PARSER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// check prop on every edge outside reset
`define FDPP_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check prop on every edge, reset included
`define FDPP_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FDPP_ASSERT(name, clk, rst, prop, msg)
`define FDPP_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

FILE: sv/fdpp_pkg.sv
// Shared types and constants of the framed decimal packet parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package fdpp_pkg;

   typedef enum logic [2:0] {
      PH_START  = 3'd0,
      PH_HEADER = 3'd1,
      PH_LENGTH = 3'd2,
      PH_DATA   = 3'd3,
      PH_CHECK  = 3'd4,
      PH_TERM   = 3'd5
   } phase_type;

   localparam logic [1:0] KIND_LENGTH = 2'd0;
   localparam logic [1:0] KIND_DATA   = 2'd1;
   localparam logic [1:0] KIND_CHECK  = 2'd2;
   localparam logic [1:0] KIND_END    = 2'd3;

   localparam logic [2:0] CSR_START_CODE  = 3'd0;
   localparam logic [2:0] CSR_HEADER_CODE = 3'd1;
   localparam logic [2:0] CSR_END_CODE    = 3'd2;
   localparam logic [2:0] CSR_CLOSE_DELIM = 3'd3;
   localparam logic [2:0] CSR_BYTE_LIMIT  = 3'd4;

   localparam logic [7:0] START_CODE_RST  = 8'h2A;
   localparam logic [7:0] HEADER_CODE_RST = 8'h2B;
   localparam logic [7:0] END_CODE_RST    = 8'h5E;
   localparam logic [7:0] CLOSE_DELIM_RST = 8'h3E;
   localparam logic [2:0] BYTE_LIMIT_RST  = 3'd6;

   localparam logic [7:0]  SKIP_BYTE  = 8'hFF;
   localparam logic [7:0]  MINUS_BYTE = 8'h2D;
   localparam logic [7:0]  DIGIT_LO   = 8'h30;
   localparam logic [7:0]  DIGIT_HI   = 8'h39;
   localparam logic [16:0] ACCUM_MAX  = 17'd99999;

   typedef struct packed {
      logic [7:0] start_code;
      logic [7:0] header_code;
      logic [7:0] end_code;
      logic [7:0] close_delim;
      logic [2:0] number_byte_limit;
   } cfg_type;

   typedef struct packed {
      logic               done;
      logic signed [17:0] value;
      logic [16:0]        accum;
      logic               neg;
      logic [2:0]         count;
   } num_type;

endpackage

`default_nettype wire

FILE: sv/fdpp_num.sv
// Decimal number reader: next accumulator state and finished value for one byte.
// Depends on fdpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fdpp_num (
   input  wire logic [7:0]       rx_byte,
   input  wire logic [16:0]      accum,
   input  wire logic             neg,
   input  wire logic [2:0]       count,
   input  wire logic [7:0]       close_delim,
   input  wire logic [2:0]       number_byte_limit,
   output fdpp_pkg::num_type     num
);
   import fdpp_pkg::*;

   logic [2:0]         count_inc;
   logic [19:0]        scaled;
   logic [16:0]        accum_sat;
   logic signed [17:0] magnitude;
   logic               is_digit;

   assign count_inc = count + 3'd1;
   assign is_digit  = (rx_byte >= DIGIT_LO) && (rx_byte <= DIGIT_HI);
   assign scaled    = ({3'b0, accum} << 3) + ({3'b0, accum} << 1)
                    + {16'b0, rx_byte[3:0]};
   assign accum_sat = (scaled > {3'b0, ACCUM_MAX}) ? ACCUM_MAX : scaled[16:0];
   assign magnitude = $signed({1'b0, accum});

   always_comb begin
      num.done  = 1'b0;
      num.value = '0;
      num.accum = accum;
      num.neg   = neg;
      num.count = count;
      if (rx_byte == SKIP_BYTE) begin
         num.count = count;
      end else if (rx_byte == close_delim) begin
         num.done  = 1'b1;
         num.value = neg ? -magnitude : magnitude;
         num.accum = '0;
         num.neg   = 1'b0;
         num.count = '0;
      end else begin
         num.count = count_inc;
         if (is_digit) begin
            num.accum = accum_sat;
         end else if (rx_byte == MINUS_BYTE) begin
            num.neg = 1'b1;
         end
         if (count_inc >= number_byte_limit) begin
            num.done  = 1'b1;
            num.value = -18'sd1;
            num.accum = '0;
            num.neg   = 1'b0;
            num.count = '0;
         end
      end
   end

endmodule

`default_nettype wire

FILE: sv/fdpp_core.sv
// Frame sequencer and result register of the framed decimal packet parser.
// Depends on fdpp_pkg, fdpp_num and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "framed_decimal_packet_parser_top_assert.svh"

module fdpp_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire fdpp_pkg::cfg_type   cfg,
   input  wire logic                item_valid,
   input  wire logic [7:0]          item_byte,
   output logic                     item_take,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [1:0]               rsp_kind,
   output logic [8:0]               rsp_entry_index,
   output logic signed [17:0]       rsp_entry_value,
   output logic                     rsp_frame_good
);
   import fdpp_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [16:0]        accum_ff, accum_in;
   logic               neg_ff, neg_in;
   logic [2:0]         count_ff, count_in;
   logic [7:0]         len_ff, len_in;
   logic [8:0]         idx_ff, idx_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         kind_ff;
   logic [8:0]         index_ff;
   logic signed [17:0] value_ff;
   logic               good_ff;

   logic               emit;
   logic [1:0]         emit_kind;
   logic [8:0]         emit_index;
   logic signed [17:0] emit_value;
   logic               emit_good;

   num_type            num;

   fdpp_num u_num (
      .rx_byte           (item_byte),
      .accum             (accum_ff),
      .neg               (neg_ff),
      .count             (count_ff),
      .close_delim       (cfg.close_delim),
      .number_byte_limit (cfg.number_byte_limit),
      .num               (num)
   );

   assign item_take = item_valid && (!rsp_valid_ff || !rsp_stall);

   // next state
   always_comb begin
      phase_in = phase_ff;
      accum_in = accum_ff;
      neg_in   = neg_ff;
      count_in = count_ff;
      len_in   = len_ff;
      idx_in   = idx_ff;
      case (phase_ff)
         PH_START: begin
            if (item_byte != cfg.start_code) begin
               accum_in = '0;
               neg_in   = 1'b0;
               count_in = '0;
            end else begin
               phase_in = PH_HEADER;
            end
         end
         PH_HEADER: begin
            accum_in = '0;
            neg_in   = 1'b0;
            count_in = '0;
            phase_in = (item_byte != cfg.header_code) ? PH_START : PH_LENGTH;
         end
         PH_LENGTH: begin
            accum_in = num.accum;
            neg_in   = num.neg;
            count_in = num.count;
            if (num.done) begin
               len_in   = num.value[7:0];
               idx_in   = 9'd1;
               phase_in = (num.value[7:0] == 8'd0) ? PH_CHECK : PH_DATA;
            end
         end
         PH_DATA: begin
            accum_in = num.accum;
            neg_in   = num.neg;
            count_in = num.count;
            if (num.done) begin
               idx_in = idx_ff + 9'd1;
               if (idx_ff >= {1'b0, len_ff}) begin
                  phase_in = PH_CHECK;
               end
            end
         end
         PH_CHECK: begin
            accum_in = num.accum;
            neg_in   = num.neg;
            count_in = num.count;
            if (num.done) begin
               idx_in   = idx_ff + 9'd1;
               phase_in = PH_TERM;
            end
         end
         PH_TERM: begin
            accum_in = '0;
            neg_in   = 1'b0;
            count_in = '0;
            phase_in = PH_START;
         end
         default: begin
            phase_in = PH_START;
         end
      endcase
   end

   // result selection
   always_comb begin
      emit       = 1'b0;
      emit_kind  = KIND_END;
      emit_index = '0;
      emit_value = '0;
      emit_good  = 1'b0;
      case (phase_ff)
         PH_START: begin
            emit = (item_byte != cfg.start_code);
         end
         PH_HEADER: begin
            emit = (item_byte != cfg.header_code);
         end
         PH_LENGTH: begin
            emit       = num.done;
            emit_kind  = KIND_LENGTH;
            emit_value = $signed({10'b0, num.value[7:0]});
         end
         PH_DATA: begin
            emit       = num.done;
            emit_kind  = KIND_DATA;
            emit_index = idx_ff;
            emit_value = num.value;
         end
         PH_CHECK: begin
            emit       = num.done;
            emit_kind  = KIND_CHECK;
            emit_index = idx_ff;
            emit_value = num.value;
         end
         PH_TERM: begin
            emit      = 1'b1;
            emit_good = (item_byte == cfg.end_code);
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (item_take) begin
         rsp_valid_in = emit;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         accum_ff     <= '0;
         neg_ff       <= 1'b0;
         count_ff     <= '0;
         len_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (item_take) begin
            phase_ff <= phase_in;
            accum_ff <= accum_in;
            neg_ff   <= neg_in;
            count_ff <= count_in;
            len_ff   <= len_in;
            idx_ff   <= idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_take && emit) begin
         kind_ff  <= emit_kind;
         index_ff <= emit_index;
         value_ff <= emit_value;
         good_ff  <= emit_good;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_entry_index = index_ff;
   assign rsp_entry_value = value_ff;
   assign rsp_frame_good  = good_ff;

   `FDPP_ASSERT(a_drain_clears, clock, reset,
      (rsp_valid_ff && !rsp_stall && !item_take) |=> !rsp_valid_ff,
      "result register kept a transferred result")
   `FDPP_ASSERT(a_stall_holds_slot, clock, reset,
      (rsp_valid_ff && rsp_stall) |-> !item_take,
      "byte consumed while result register is blocked")
   `FDPP_ASSERT(a_header_exit, clock, reset,
      (item_take && phase_ff == PH_HEADER) |=>
         (phase_ff == PH_LENGTH || phase_ff == PH_START),
      "header byte led to an unexpected phase")
   `FDPP_ASSERT(a_end_payload, clock, reset,
      (rsp_valid_ff && rsp_kind == KIND_END) |->
         (rsp_entry_index == 9'd0 && rsp_entry_value == 18'sd0),
      "frame-end result carries a nonzero index or value")

endmodule

`default_nettype wire

FILE: sv/framed_decimal_packet_parser_top.sv
// Framed decimal packet parser, top level: byte input register and CSRs.
// Depends on fdpp_pkg and fdpp_core.
// Usage:
//   req_*  : one received byte per transfer (valid/stall); 0xFF is skipped
//            inside numbers.
//   rsp_*  : at most one result per byte: length, data value, check number
//            or frame end with good/bad (valid/stall).
//   csr_*  : register writes (valid/ready, always ready); index 0 start code,
//            1 header code, 2 end code, 3 close delimiter, 4 byte limit.
//            Write only while the block is idle.
// Path: a transferred byte is held in the input register, and its result
//   is then held in the result register.
// Throughput: one byte per cycle unless rsp_stall holds a pending result;
//   the parse logic between the input and result registers is single-pass.
// Stall: while rsp_stall holds a pending result, the input register keeps
//   its byte and req_stall rises once it is full; no result is lost.
// Reset: synchronous; registers return to their default codes and the
//   parser waits for a start byte with both registers empty.
`timescale 1ns / 1ps
`default_nettype none

module framed_decimal_packet_parser_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [7:0]        req_rx_byte,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [1:0]             rsp_kind,
   output logic [8:0]             rsp_entry_index,
   output logic signed [17:0]     rsp_entry_value,
   output logic                   rsp_frame_good,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [2:0]        csr_index,
   input  wire logic [7:0]        csr_data
);
   import fdpp_pkg::*;

   cfg_type    cfg_ff;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       item_take;
   logic       req_xfer;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_code        <= START_CODE_RST;
         cfg_ff.header_code       <= HEADER_CODE_RST;
         cfg_ff.end_code          <= END_CODE_RST;
         cfg_ff.close_delim       <= CLOSE_DELIM_RST;
         cfg_ff.number_byte_limit <= BYTE_LIMIT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_START_CODE:  cfg_ff.start_code        <= csr_data;
            CSR_HEADER_CODE: cfg_ff.header_code       <= csr_data;
            CSR_END_CODE:    cfg_ff.end_code          <= csr_data;
            CSR_CLOSE_DELIM: cfg_ff.close_delim       <= csr_data;
            CSR_BYTE_LIMIT:  cfg_ff.number_byte_limit <= csr_data[2:0];
            default: begin
            end
         endcase
      end
   end

   assign req_stall = in_valid_ff && !item_take;
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (item_take) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   fdpp_core u_core (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .item_valid      (in_valid_ff),
      .item_byte       (in_byte_ff),
      .item_take       (item_take),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_entry_index (rsp_entry_index),
      .rsp_entry_value (rsp_entry_value),
      .rsp_frame_good  (rsp_frame_good)
   );

endmodule

`default_nettype wire
